@@ rtl/psx_pkg.sv @@
// ----------------------------------------------------------------------------
// psx_pkg
// Shared types and constants for the PostScript string text extractor.
// ----------------------------------------------------------------------------
package psx_pkg;

    localparam int DEPTH_W = 8;
    localparam logic [DEPTH_W-1:0] MAX_NEST = 8'd255;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NL      = 8'h0A;

    // Output queue geometry: room for two results from one request plus slack.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [DEPTH_W-1:0] nest_depth;
        logic               escape_pending;
        logic               in_comment;
        logic               line_has_output;
    } t_parse_state;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_result_pair;

endpackage

@@ rtl/psx_decode.sv @@
// ----------------------------------------------------------------------------
// psx_decode
// Combinational parser step: next line state and up to two results per request.
// ----------------------------------------------------------------------------
module psx_decode
    import psx_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_char_in,
    input  logic         i_line_end,
    output t_parse_state o_state,
    output t_result_pair o_results
);

    logic       in_string;
    logic [1:0] cnt;
    logic [7:0] c0;
    logic [7:0] c1;

    always_comb begin
        in_string = (i_state.nest_depth != '0);
        o_state   = i_state;
        cnt       = 2'd0;
        c0        = i_char_in;
        c1        = i_char_in;

        priority if (i_line_end) begin
            c0      = CH_NL;
            cnt     = i_state.line_has_output ? 2'd1 : 2'd0;
            o_state = '0;
        end else if (i_state.in_comment) begin
            cnt = 2'd0;
        end else if (i_state.escape_pending) begin
            o_state.escape_pending = 1'b0;
            if (i_char_in == CH_LPAREN || i_char_in == CH_RPAREN ||
                i_char_in == CH_BSLASH) begin
                cnt = 2'd1;
            end else begin
                cnt = 2'd2;
                c0  = CH_BSLASH;
            end
        end else if (!in_string && i_char_in == CH_PERCENT) begin
            o_state.in_comment = 1'b1;
        end else if (i_char_in == CH_LPAREN) begin
            cnt = in_string ? 2'd1 : 2'd0;
            if (i_state.nest_depth < MAX_NEST) begin
                o_state.nest_depth = i_state.nest_depth + 1'b1;
            end
        end else if (i_char_in == CH_RPAREN) begin
            if (in_string) begin
                o_state.nest_depth = i_state.nest_depth - 1'b1;
                cnt = 2'd1;
                c0  = (i_state.nest_depth == {{(DEPTH_W-1){1'b0}}, 1'b1}) ?
                      CH_SPACE : CH_RPAREN;
            end
        end else if (in_string && i_char_in == CH_BSLASH) begin
            o_state.escape_pending = 1'b1;
        end else if (in_string) begin
            cnt = 2'd1;
        end

        // End of line clears everything, including the output flag.
        if (!i_line_end && cnt != 2'd0) begin
            o_state.line_has_output = 1'b1;
        end

        o_results.count           = cnt;
        o_results.first.char_out  = c0;
        o_results.first.last      = (cnt == 2'd1);
        o_results.second.char_out = c1;
        o_results.second.last     = 1'b1;
    end

endmodule

@@ rtl/psx_outq.sv @@
// ----------------------------------------------------------------------------
// psx_outq
// Small result queue: takes zero to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module psx_outq
    import psx_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_result_pair i_push,
    output logic         o_room,
    output logic         o_valid,
    input  logic         i_ready,
    output t_result      o_head
);

    t_result          r_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wr_ptr;
    logic [OQ_AW-1:0] r_rd_ptr;
    logic [OQ_CW-1:0] r_count;
    logic [OQ_AW-1:0] n_wr_ptr;
    logic [OQ_AW-1:0] n_rd_ptr;
    logic [OQ_CW-1:0] n_count;
    logic [OQ_AW-1:0] wr_ptr_1;
    logic             pop;

    // Accept only while the worst case of two results still fits.
    assign o_room   = (r_count <= OQ_CW'(OQ_DEPTH - 2));
    assign o_valid  = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    assign pop      = o_valid && i_ready;
    assign wr_ptr_1 = r_wr_ptr + 1'b1;

    always_comb begin
        n_wr_ptr = r_wr_ptr + OQ_AW'(i_push.count);
        n_rd_ptr = r_rd_ptr + OQ_AW'(pop);
        n_count  = r_count + OQ_CW'(i_push.count) - OQ_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_1] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/postscript_string_text_extractor_core.sv @@
// ----------------------------------------------------------------------------
// postscript_string_text_extractor_core
// Extracts the text of parenthesized string literals from a PostScript stream.
// ----------------------------------------------------------------------------
// Usage: each input request carries either one source byte (i_line_end low)
// or an end-of-line mark (i_line_end high, i_char_in ignored). Each output
// request carries one extracted byte, with o_last high on the final byte
// that a given input request produced. An input request may produce zero,
// one or two output requests; two only for an escape that keeps its
// backslash.
// Results of an accepted request are written into the output queue and
// offered from its head. Throughput: one input request per cycle while
// the receiver keeps up. The limit is the four-entry output queue, which
// must hold room for two results before a request is taken, so a stalled
// receiver stops input once three or four results are queued.
// Reset (synchronous, active low) clears the nesting depth, the escape and
// comment flags, the line flag and the output queue; nothing is offered
// until new input arrives.
// ----------------------------------------------------------------------------
module postscript_string_text_extractor_core
    import psx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_char_in,
    input  logic       i_line_end,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_char_out,
    output logic       o_last
);

    t_parse_state r_state;
    t_parse_state n_state;
    t_parse_state dec_state;
    t_result_pair dec_results;
    t_result_pair push;
    t_result      head;
    logic         accept;
    logic         room;

    // The parser step works on the current line state and the new byte.
    psx_decode u_decode (
        .i_state   (r_state),
        .i_char_in (i_char_in),
        .i_line_end(i_line_end),
        .o_state   (dec_state),
        .o_results (dec_results)
    );

    assign o_in_ready = room;
    assign accept     = i_in_valid && room;

    // Nothing is pushed or updated unless the request is actually taken.
    always_comb begin
        push    = dec_results;
        n_state = r_state;
        if (accept) begin
            n_state = dec_state;
        end else begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    // The queue decouples the two sides so input keeps flowing while a
    // finished result waits.
    psx_outq u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .o_room (room),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_head (head)
    );

    assign o_char_out = head.char_out;
    assign o_last     = head.last;

endmodule

@@ rtl/psx_checker.sv @@
// ----------------------------------------------------------------------------
// psx_checker
// Port-level checks for the string text extractor, bound to the top level.
// ----------------------------------------------------------------------------
module psx_checker
    import psx_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic [7:0] i_char_in,
    input logic       i_line_end,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_char_out,
    input logic       o_last
);

    // A waiting input request holds until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=>
            i_in_valid && $stable(i_char_in) && $stable(i_line_end))
        else $error("input changed while waiting");

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_char_out) && $stable(o_last))
        else $error("output changed while stalled");

    // Only a kept escape gives two results, and its first one is the backslash.
    a_first_of_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> o_char_out == CH_BSLASH)
        else $error("non-final result is not a backslash");

    // Input is refused only while results are queued.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input refused with empty queue");

    // Reset empties the queue.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

endmodule

bind postscript_string_text_extractor_core psx_checker u_psx_checker (.*);
